### sv/hsl_to_rgb_converter_macros.svh
// assertion macros for the hsl to rgb converter
`ifndef HSL_TO_RGB_CONVERTER_MACROS_SVH
`define HSL_TO_RGB_CONVERTER_MACROS_SVH

`ifndef ASSERT_OFF
// antecedent implies consequent in the same cycle
`define HSLRGB_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// antecedent implies consequent in the next cycle
`define HSLRGB_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
// antecedent implies consequent after the delay given by argument n
`define HSLRGB_ASSERT_DELAY(lbl, clk, rst, ante, n, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##n (cons)) else $error(msg);
`else
`define HSLRGB_ASSERT_SAME(lbl, clk, rst, ante, cons, msg)
`define HSLRGB_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`define HSLRGB_ASSERT_DELAY(lbl, clk, rst, ante, n, cons, msg)
`endif

`endif

### sv/hslrgb_pkg.sv
// types and constants shared by the hsl to rgb converter
package hslrgb_pkg;

  localparam int CH_BITS  = 16;
  localparam int HUE_BITS = 14;
  localparam int HUE_MAG_BITS = HUE_BITS - 1;
  localparam int T_BITS   = 10;   // holds 0..960
  localparam int DIV_SHIFT = 6;   // 960 = 64 * 15
  localparam int Q_BITS   = CH_BITS + T_BITS - DIV_SHIFT;
  localparam int RECIP_SHIFT = 24;
  localparam int RECIP_BITS  = 21;

  localparam logic [CH_BITS:0] CH_ONE = {1'b1, {CH_BITS{1'b0}}};
  localparam logic [CH_BITS-1:0] CH_MAX = {CH_BITS{1'b1}};

  localparam logic [HUE_MAG_BITS-1:0] HUE_SECTOR = 13'd960;
  localparam logic [HUE_MAG_BITS-1:0] HUE_DOUBLE = 13'd1920;
  localparam logic [HUE_MAG_BITS-1:0] HUE_EDGE2  = 13'd2880;
  localparam logic [HUE_MAG_BITS-1:0] HUE_EDGE3  = 13'd3840;
  localparam logic [HUE_MAG_BITS-1:0] HUE_EDGE4  = 13'd4800;
  localparam logic [HUE_MAG_BITS-1:0] HUE_TURN   = 13'd5760;

  // floor(2^24 / 15)
  localparam logic [RECIP_BITS-1:0] RECIP15 = 21'd1118481;
  localparam logic [Q_BITS-1:0] DIV_ODD = 20'd15;

  typedef enum logic [2:0] {
    SECT_RED_YEL,
    SECT_YEL_GRN,
    SECT_GRN_CYA,
    SECT_CYA_BLU,
    SECT_BLU_MAG,
    SECT_MAG_RED
  } sector_t;

  typedef struct packed {
    logic signed [HUE_BITS-1:0] hue;
    logic [CH_BITS-1:0]         saturation;
    logic [CH_BITS-1:0]         lightness;
  } hsl_t;

  typedef struct packed {
    logic [CH_BITS-1:0] red;
    logic [CH_BITS-1:0] green;
    logic [CH_BITS-1:0] blue;
  } rgb_t;

  typedef struct packed {
    logic    valid;
    logic    achrom;
    sector_t sector;
  } tag_t;

  typedef struct packed {
    logic [CH_BITS-1:0] c;
    logic [CH_BITS-1:0] l;
    logic [T_BITS-1:0]  t;
  } chroma_t;

  typedef struct packed {
    logic [CH_BITS-1:0] c;
    logic [CH_BITS-1:0] x;
    logic [CH_BITS-1:0] m;
  } mixin_t;

endpackage

### sv/hslrgb_chroma.sv
// hue reduction and chroma, two pipeline stages
module hslrgb_chroma import hslrgb_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  input  hsl_t    hsl,
  output tag_t    tag,
  output chroma_t chroma
);

  logic [CH_BITS:0]        twol;
  logic [CH_BITS:0]        ldev;
  logic [CH_BITS:0]        k_next;
  logic [HUE_MAG_BITS-1:0] hmag;
  logic [HUE_MAG_BITS-1:0] h;
  logic [HUE_MAG_BITS-1:0] r;
  logic [T_BITS-1:0]       t_next;
  tag_t                    tag_next;

  // stage one registers
  tag_t               tag1;
  logic [CH_BITS:0]   k1;
  logic [CH_BITS-1:0] s1;
  logic [CH_BITS-1:0] l1;
  logic [T_BITS-1:0]  t1;

  logic [2*CH_BITS:0] prod;

  always_comb begin
    twol = {hsl.lightness, 1'b0};
    ldev = (twol >= CH_ONE) ? (twol - CH_ONE) : (CH_ONE - twol);
    k_next = CH_ONE - ldev;

    hmag = hsl.hue[HUE_MAG_BITS-1:0];
    h = (hmag > HUE_TURN) ? (hmag - HUE_TURN) : hmag;

    // hue mod two sectors
    if (h >= HUE_TURN) begin
      r = h - HUE_TURN;
    end else if (h >= HUE_EDGE3) begin
      r = h - HUE_EDGE3;
    end else if (h >= HUE_DOUBLE) begin
      r = h - HUE_DOUBLE;
    end else begin
      r = h;
    end
    t_next = (r < HUE_SECTOR) ? r[T_BITS-1:0] : T_BITS'(HUE_DOUBLE - r);

    tag_next.valid  = in_valid;
    tag_next.achrom = hsl.hue[HUE_BITS-1];
    // upper boundary belongs to the lower sector
    if (h <= HUE_SECTOR) begin
      tag_next.sector = SECT_RED_YEL;
    end else if (h <= HUE_DOUBLE) begin
      tag_next.sector = SECT_YEL_GRN;
    end else if (h <= HUE_EDGE2) begin
      tag_next.sector = SECT_GRN_CYA;
    end else if (h <= HUE_EDGE3) begin
      tag_next.sector = SECT_CYA_BLU;
    end else if (h <= HUE_EDGE4) begin
      tag_next.sector = SECT_BLU_MAG;
    end else begin
      tag_next.sector = SECT_MAG_RED;
    end
  end

  assign prod = k1 * {1'b0, s1};

  always_ff @(posedge clk) begin
    k1 <= k_next;
    s1 <= hsl.saturation;
    l1 <= hsl.lightness;
    t1 <= t_next;

    chroma.c <= prod[2*CH_BITS-1:CH_BITS];
    chroma.l <= l1;
    chroma.t <= t1;

    if (rst) begin
      tag1 <= '0;
      tag <= '0;
    end else begin
      tag1 <= tag_next;
      tag <= tag1;
    end
  end

endmodule

### sv/hslrgb_xscale.sv
// x term and offset m, three pipeline stages with a divide by 960
`include "hsl_to_rgb_converter_macros.svh"
module hslrgb_xscale import hslrgb_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  tag_t    tag_in,
  input  chroma_t chroma,
  output tag_t    tag,
  output mixin_t  mix
);

  logic [CH_BITS+T_BITS-1:0] prod3;
  logic [CH_BITS-1:0]        m_next;

  tag_t               tag3;
  logic [Q_BITS-1:0]  q3;
  logic [CH_BITS-1:0] c3;
  logic [CH_BITS-1:0] m3;

  logic [Q_BITS+RECIP_BITS-1:0] est;

  tag_t               tag4;
  logic [CH_BITS-1:0] q4;
  logic [Q_BITS-1:0]  n4;
  logic [CH_BITS-1:0] c4;
  logic [CH_BITS-1:0] m4;

  logic [Q_BITS-1:0]  times15;
  logic [Q_BITS-1:0]  rem;
  logic [CH_BITS-1:0] x_next;

  assign prod3  = chroma.c * chroma.t;
  assign m_next = chroma.l - {1'b0, chroma.c[CH_BITS-1:1]};

  // reciprocal estimate is at most one short
  assign est = q3 * RECIP15;

  assign times15 = {q4, 4'b0000} - {4'b0000, q4};
  assign rem     = n4 - times15;
  assign x_next  = (rem >= DIV_ODD) ? (q4 + 1'b1) : q4;

  always_ff @(posedge clk) begin
    q3 <= prod3[CH_BITS+T_BITS-1:DIV_SHIFT];
    c3 <= chroma.c;
    m3 <= m_next;

    q4 <= est[RECIP_SHIFT+CH_BITS-1:RECIP_SHIFT];
    n4 <= q3;
    c4 <= c3;
    m4 <= m3;

    mix.c <= c4;
    mix.x <= x_next;
    mix.m <= m4;

    if (rst) begin
      tag3 <= '0;
      tag4 <= '0;
      tag <= '0;
    end else begin
      tag3 <= tag_in;
      tag4 <= tag3;
      tag <= tag4;
    end
  end

  `HSLRGB_ASSERT_SAME(a_x_le_c, clk, rst, tag.valid, mix.x <= mix.c, "x term above chroma")
  `HSLRGB_ASSERT_SAME(a_rem_small, clk, rst, tag4.valid, rem < 20'd30, "divide estimate off")
  `HSLRGB_ASSERT_NEXT(a_valid_walk, clk, rst, tag3.valid, tag4.valid, "valid bit lost")

endmodule

### sv/hslrgb_mix.sv
// channel placement by sector, offset add and saturation
`include "hsl_to_rgb_converter_macros.svh"
module hslrgb_mix import hslrgb_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  tag_t   tag,
  input  mixin_t mix,
  output logic   done,
  output rgb_t   rgb
);

  logic [CH_BITS-1:0] rc;
  logic [CH_BITS-1:0] gc;
  logic [CH_BITS-1:0] bc;
  logic [CH_BITS:0]   rs;
  logic [CH_BITS:0]   gs;
  logic [CH_BITS:0]   bs;
  rgb_t               rgb_next;

  always_comb begin
    rc = '0;
    gc = '0;
    bc = '0;
    if (!tag.achrom) begin
      case (tag.sector)
        SECT_RED_YEL: begin rc = mix.c; gc = mix.x; end
        SECT_YEL_GRN: begin rc = mix.x; gc = mix.c; end
        SECT_GRN_CYA: begin gc = mix.c; bc = mix.x; end
        SECT_CYA_BLU: begin gc = mix.x; bc = mix.c; end
        SECT_BLU_MAG: begin rc = mix.x; bc = mix.c; end
        default: begin rc = mix.c; bc = mix.x; end
      endcase
    end
    rs = {1'b0, rc} + {1'b0, mix.m};
    gs = {1'b0, gc} + {1'b0, mix.m};
    bs = {1'b0, bc} + {1'b0, mix.m};
    rgb_next.red   = rs[CH_BITS] ? CH_MAX : rs[CH_BITS-1:0];
    rgb_next.green = gs[CH_BITS] ? CH_MAX : gs[CH_BITS-1:0];
    rgb_next.blue  = bs[CH_BITS] ? CH_MAX : bs[CH_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    rgb <= rgb_next;
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= tag.valid;
    end
  end

  `HSLRGB_ASSERT_NEXT(a_grey, clk, rst, tag.valid && tag.achrom, (rgb.red == rgb.green) && (rgb.green == rgb.blue), "achromatic item not grey")
  `HSLRGB_ASSERT_NEXT(a_floor_m, clk, rst, tag.valid, (rgb.red == $past(mix.m)) || (rgb.green == $past(mix.m)) || (rgb.blue == $past(mix.m)), "no channel at offset m")
  `HSLRGB_ASSERT_NEXT(a_done_follow, clk, rst, tag.valid, done, "strobe missing")

endmodule

### sv/hsl_to_rgb_converter.sv
// top level of the hsl to rgb converter
//
//   channel  | handshake          | payload
//   ---------+--------------------+------------------------------------------
//   input    | start, busy        | hsl (hue, saturation, lightness)
//   output   | done (strobe)      | rgb (red, green, blue)
//
// one transaction in per clock while busy is low, one result out per transaction
// pipeline stages: hue/chroma (2 stages), x scale and divide by 960
//   (3 stages, set by the two multipliers and the reciprocal correction),
//   channel mix with saturation (1 stage)
// busy is high only in reset and the cycle after; the pipeline never fills up
// the receiver takes done/rgb for exactly one cycle and cannot stall
// synchronous reset clears the valid bits of every stage
`include "hsl_to_rgb_converter_macros.svh"
module hsl_to_rgb_converter import hslrgb_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  hsl_t hsl,
  output logic done,
  output rgb_t rgb
);

  logic    accept;
  tag_t    tag_c;
  chroma_t chroma;
  tag_t    tag_x;
  mixin_t  mix;

  // a transaction enters whenever start is seen while busy is low
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    busy <= rst;
  end

  // stages one and two: hue sector, triangle term, chroma
  hslrgb_chroma u_chroma (
    .clk      (clk),
    .rst      (rst),
    .in_valid (accept),
    .hsl      (hsl),
    .tag      (tag_c),
    .chroma   (chroma)
  );

  // stages three to five: c times triangle over 960, offset m
  hslrgb_xscale u_xscale (
    .clk    (clk),
    .rst    (rst),
    .tag_in (tag_c),
    .chroma (chroma),
    .tag    (tag_x),
    .mix    (mix)
  );

  // stage six: sector placement, add m, saturate, output register
  hslrgb_mix u_mix (
    .clk  (clk),
    .rst  (rst),
    .tag  (tag_x),
    .mix  (mix),
    .done (done),
    .rgb  (rgb)
  );

  `HSLRGB_ASSERT_DELAY(a_latency, clk, rst, accept, 6, done, "result not out after six cycles")
  `HSLRGB_ASSERT_SAME(a_no_extra, clk, rst, done, $past(accept, 6), "result without transaction")
  `HSLRGB_ASSERT_NEXT(a_busy_reset, clk, 1'b0, rst, busy, "busy low after reset")

endmodule

### dv/testbench.sv
// self-checking testbench for the hsl to rgb converter: directed corners, random pixels
class rgb_checker;
  hslrgb_pkg::rgb_t pending_rgb[$];
  int unsigned mismatches;

  function new();
    mismatches = 0;
  endfunction

  // expected color of one pixel
  function hslrgb_pkg::rgb_t convert(hslrgb_pkg::hsl_t px);
    logic [hslrgb_pkg::HUE_BITS-1:0]     hraw;
    logic [hslrgb_pkg::HUE_MAG_BITS-1:0] h, r, d, sect_idx;
    logic [hslrgb_pkg::CH_BITS:0]        twol, ldev, k, sum_r, sum_g, sum_b;
    logic [2*hslrgb_pkg::CH_BITS:0]      ks;
    logic [hslrgb_pkg::CH_BITS+9:0]      xp;
    logic [hslrgb_pkg::CH_BITS-1:0]      c, m, x, rc, gc, bc;
    hslrgb_pkg::sector_t                 sect;
    hslrgb_pkg::rgb_t                    res;
    hraw = px.hue;
    twol = {px.lightness, 1'b0};
    ldev = (twol >= hslrgb_pkg::CH_ONE) ? twol - hslrgb_pkg::CH_ONE
                                        : hslrgb_pkg::CH_ONE - twol;
    k = hslrgb_pkg::CH_ONE - ldev;
    ks = (2*hslrgb_pkg::CH_BITS+1)'(k) * (2*hslrgb_pkg::CH_BITS+1)'(px.saturation);
    c = ks[hslrgb_pkg::CH_BITS +: hslrgb_pkg::CH_BITS];
    m = px.lightness - (c >> 1);
    rc = '0;
    gc = '0;
    bc = '0;
    if (!hraw[hslrgb_pkg::HUE_BITS-1]) begin
      h = hraw[hslrgb_pkg::HUE_MAG_BITS-1:0];
      if (h > hslrgb_pkg::HUE_TURN) h = h - hslrgb_pkg::HUE_TURN;
      r = h % hslrgb_pkg::HUE_DOUBLE;
      d = (r >= hslrgb_pkg::HUE_SECTOR) ? r - hslrgb_pkg::HUE_SECTOR
                                        : hslrgb_pkg::HUE_SECTOR - r;
      xp = (hslrgb_pkg::CH_BITS+10)'(c) * (hslrgb_pkg::CH_BITS+10)'(hslrgb_pkg::HUE_SECTOR - d);
      x = hslrgb_pkg::CH_BITS'(xp / hslrgb_pkg::HUE_SECTOR);
      sect_idx = (h == '0) ? '0 : (h - 1'b1) / hslrgb_pkg::HUE_SECTOR;
      sect = hslrgb_pkg::sector_t'(sect_idx[2:0]);
      case (sect)
        hslrgb_pkg::SECT_RED_YEL: begin rc = c; gc = x; end
        hslrgb_pkg::SECT_YEL_GRN: begin rc = x; gc = c; end
        hslrgb_pkg::SECT_GRN_CYA: begin gc = c; bc = x; end
        hslrgb_pkg::SECT_CYA_BLU: begin gc = x; bc = c; end
        hslrgb_pkg::SECT_BLU_MAG: begin rc = x; bc = c; end
        default:                  begin rc = c; bc = x; end
      endcase
    end
    sum_r = {1'b0, m} + {1'b0, rc};
    sum_g = {1'b0, m} + {1'b0, gc};
    sum_b = {1'b0, m} + {1'b0, bc};
    res.red   = sum_r[hslrgb_pkg::CH_BITS] ? hslrgb_pkg::CH_MAX
                                           : sum_r[hslrgb_pkg::CH_BITS-1:0];
    res.green = sum_g[hslrgb_pkg::CH_BITS] ? hslrgb_pkg::CH_MAX
                                           : sum_g[hslrgb_pkg::CH_BITS-1:0];
    res.blue  = sum_b[hslrgb_pkg::CH_BITS] ? hslrgb_pkg::CH_MAX
                                           : sum_b[hslrgb_pkg::CH_BITS-1:0];
    return res;
  endfunction

  function void note_input(hslrgb_pkg::hsl_t px);
    pending_rgb.push_back(convert(px));
  endfunction

  function void check_result(hslrgb_pkg::rgb_t got);
    hslrgb_pkg::rgb_t want;
    if (pending_rgb.size() == 0) begin
      $display("%0t: unexpected result r=%h g=%h b=%h", $time, got.red, got.green, got.blue);
      mismatches++;
      return;
    end
    want = pending_rgb.pop_front();
    if (got.red !== want.red) begin
      $display("%0t: red expected %h actual %h", $time, want.red, got.red);
      mismatches++;
    end
    if (got.green !== want.green) begin
      $display("%0t: green expected %h actual %h", $time, want.green, got.green);
      mismatches++;
    end
    if (got.blue !== want.blue) begin
      $display("%0t: blue expected %h actual %h", $time, want.blue, got.blue);
      mismatches++;
    end
  endfunction
endclass

module testbench import hslrgb_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  // no accepted transaction and no result for this many cycles ends the run
  localparam int unsigned STALL_LIMIT  = 1000;
  localparam int unsigned RANDOM_ITEMS = 1350;
  // pipeline is six deep, DRAIN_CYCLES is longer than that
  localparam int unsigned DRAIN_CYCLES = 12;

  logic clk   = 1'b0;
  logic rst   = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic done;
  hsl_t hsl   = '0;
  rgb_t rgb;

  rgb_checker  sb;
  int unsigned quiet_cycles = 0;

  hsl_to_rgb_converter DUT (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .hsl   (hsl),
    .done  (done),
    .rgb   (rgb)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // monitor: inputs and results are sampled at the edge, before the
  // nonblocking updates of that edge land, so nothing races
  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= quiet_cycles + 1;
    end else begin
      // a transaction is taken when start is high and busy is low
      if (start && !busy) sb.note_input(hsl);
      // the strobe marks a result that is only there for this cycle
      if (done) sb.check_result(rgb);
      if ((start && !busy) || done) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
    end
  end

  // watchdog on a hung handshake
  initial begin
    while (quiet_cycles < STALL_LIMIT) @(posedge clk);
    $display("Some tests failed");
    $finish;
  end

  function automatic hsl_t make_pixel(int h, int s, int l);
    hsl_t px;
    px.hue        = HUE_BITS'(h);
    px.saturation = CH_BITS'(s);
    px.lightness  = CH_BITS'(l);
    return px;
  endfunction

  // saturation and lightness, leaning on the ends of the range now and then
  function automatic int pick_fraction();
    int corners[6] = '{0, 1, 32767, 32768, 65534, 65535};
    if ($urandom_range(99, 0) < 20) return corners[$urandom_range(5, 0)];
    return int'($urandom_range(65535, 0));
  endfunction

  function automatic hsl_t random_pixel();
    int pick;
    int h;
    pick = $urandom_range(99, 0);
    if (pick < 60) begin
      // normal hue range
      h = $urandom_range(5760, 0);
    end else if (pick < 75) begin
      // negative hue, achromatic, down to the most negative code
      h = -int'($urandom_range(8192, 1));
    end else if (pick < 85) begin
      // past one turn, wraps once
      h = $urandom_range(8191, 5761);
    end else begin
      // at or next to a sector edge
      h = 960 * int'($urandom_range(6, 0)) + int'($urandom_range(2, 0)) - 1;
      if (h < 0) h = 0;
    end
    return make_pixel(h, pick_fraction(), pick_fraction());
  endfunction

  // offer one transaction, idling at random first, and hold it until taken
  task automatic send_pixel(hsl_t px, int unsigned idle_pct);
    while ($urandom_range(99, 0) < idle_pct) begin
      start <= 1'b0;
      // junk on the payload while start is low must be ignored
      hsl   <= random_pixel();
      @(posedge clk);
    end
    start <= 1'b1;
    hsl   <= px;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic send_random(int unsigned count, int unsigned idle_pct);
    for (int unsigned i = 0; i < count; i++) send_pixel(random_pixel(), idle_pct);
  endtask

  initial begin
    sb = new();
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed: achromatic hues including the most negative one
    send_pixel(make_pixel(-8192, 65535, 32768), 0);
    send_pixel(make_pixel(-5760, 0, 65535), 0);
    send_pixel(make_pixel(-1, 65535, 16384), 0);
    // sector edges at full chroma; lightness one half makes c + m reach one
    // and saturate
    send_pixel(make_pixel(0, 65535, 32768), 0);
    send_pixel(make_pixel(1, 65535, 32768), 0);
    send_pixel(make_pixel(959, 65535, 32768), 0);
    send_pixel(make_pixel(960, 65535, 32768), 0);
    send_pixel(make_pixel(961, 65535, 32768), 0);
    send_pixel(make_pixel(1920, 65535, 32768), 0);
    send_pixel(make_pixel(2880, 65535, 32768), 0);
    send_pixel(make_pixel(3840, 65535, 32768), 0);
    send_pixel(make_pixel(4800, 65535, 32768), 0);
    send_pixel(make_pixel(5759, 65535, 32768), 0);
    // a full turn stays in the last sector, above it wraps
    send_pixel(make_pixel(5760, 65535, 32768), 0);
    send_pixel(make_pixel(5761, 65535, 32768), 0);
    send_pixel(make_pixel(8191, 65535, 32768), 0);
    // saturation and lightness extremes
    send_pixel(make_pixel(480, 0, 0), 0);
    send_pixel(make_pixel(480, 65535, 0), 0);
    send_pixel(make_pixel(480, 65535, 65535), 0);
    send_pixel(make_pixel(480, 0, 65535), 0);
    send_pixel(make_pixel(2000, 32768, 20000), 0);
    send_pixel(make_pixel(3000, 1, 1), 0);

    // random phases: back to back, sparse sender, back to back, moderate gaps
    send_random(RANDOM_ITEMS / 4, 0);
    send_random(RANDOM_ITEMS / 4, 73);
    send_random(RANDOM_ITEMS / 4, 0);
    send_random(RANDOM_ITEMS - 3 * (RANDOM_ITEMS / 4), 37);
    start <= 1'b0;

    // drain the pipeline, then keep watching for stray strobes
    while (sb.pending_rgb.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.mismatches == 0 && sb.pending_rgb.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
